[rtl/core/rlcf_pkg.sv]
// Shared types and constants of the linear RGB color fader.
// Used by the controller, the datapath and the top level.
package rlcf_pkg;

    localparam logic       KIND_START    = 1'b0;
    localparam logic       KIND_TICK     = 1'b1;
    localparam logic [7:0] INTERVAL_RST  = 8'd17;
    localparam int         DIV_STEPS     = 24;
    localparam int         STEP_W        = $clog2(DIV_STEPS);
    localparam int         NUM_CHAN      = 3;

    typedef enum logic [1:0] {
        SEL_SRC = 2'd0,
        SEL_TGT = 2'd1,
        SEL_MIX = 2'd2
    } t_sel;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic mix;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/rgb_linear_color_fader.sv]
// Top level of the linear RGB color fader.
// Joins rlcf_ctrl and rlcf_dpath; depends on rlcf_pkg.
//
// Input stream: one beat per start or tick item. tuser selects the kind
// (0 start, 1 one-millisecond tick); tdata carries source color, target
// color and duration for start beats and is ignored on ticks.
// Output stream: one beat per color update, tlast marks the target color
// that ends a transition. A start beat yields the source color at once
// (the target with tlast when the duration is zero); ticks yield a color
// every update_interval ticks while a transition runs.
// Start beats and final-target updates are loaded into the output register
// from the emit state; interpolated updates pass through a multiply,
// 24 steps of the per-channel restoring dividers, which run for all
// three channels side by side, and the output load. One item is in work
// at a time; tready drops from acceptance until the result is loaded, so
// the next beat waits for that load after a start beat or an interpolated
// update, while a tick that yields nothing leaves tready high. A stalled
// receiver holds the block once one result waits in the output register.
// Reset (synchronous, active low) idles the fader, empties the output
// register and sets update_interval to 17.
module rgb_linear_color_fader
    import rlcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // update_interval
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // from_rgb[23:0], to_rgb[47:24], duration_ms[63:48]
    input  logic [0:0]  s_axis_tuser,    // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    rlcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    rlcf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (s_axis_tuser[0]),
        .i_from_rgb    (s_axis_tdata[23:0]),
        .i_to_rgb      (s_axis_tdata[47:24]),
        .i_duration_ms (s_axis_tdata[63:48]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

[rtl/core/rlcf_ctrl.sv]
// Controller state machine of the color fader.
// Sequences accept, multiply, divide and output load; depends on rlcf_pkg.
module rlcf_ctrl
    import rlcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.emit) begin
                        n_state = ST_EMIT;
                    end else if (i_sts.mix) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/rlcf_dpath.sv]
// Datapath of the color fader: fade state, per-channel multiply and
// restoring dividers, output register. Depends on rlcf_pkg.
module rlcf_dpath
    import rlcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_kind,
    input  logic [23:0] i_from_rgb,
    input  logic [23:0] i_to_rgb,
    input  logic [15:0] i_duration_ms,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [23:0] o_out_data,
    output logic        o_out_last
);

    logic [7:0]        r_interval;
    logic              r_active;
    logic [7:0]        r_count;
    logic [15:0]       r_elapsed;
    logic [23:0]       r_src;
    logic [23:0]       r_tgt;
    logic [15:0]       r_span;
    t_sel              r_sel;
    logic [STEP_W-1:0] r_step;
    logic [23:0]       r_quo [NUM_CHAN];
    logic [15:0]       r_rem [NUM_CHAN];
    logic              r_neg [NUM_CHAN];
    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic              r_out_last;

    logic [8:0]  w_cnt_inc;
    logic        w_fire;
    logic [15:0] w_el_inc;
    logic        w_done;
    logic [7:0]  w_a   [NUM_CHAN];
    logic [7:0]  w_b   [NUM_CHAN];
    logic [7:0]  w_mag [NUM_CHAN];
    logic [16:0] w_trial [NUM_CHAN];
    logic        w_ge    [NUM_CHAN];
    logic [7:0]  w_chan  [NUM_CHAN];

    assign w_cnt_inc = {1'b0, r_count} + 9'd1;
    assign w_fire    = (w_cnt_inc >= {1'b0, r_interval});
    assign w_el_inc  = (r_elapsed < r_span) ? r_elapsed + 16'd1 : r_elapsed;
    assign w_done    = (w_el_inc >= r_span);

    always_comb begin
        o_sts.emit     = (i_kind == KIND_START) || (r_active && w_fire && w_done);
        o_sts.mix      = (i_kind == KIND_TICK) && r_active && w_fire && !w_done;
        o_sts.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            w_a[k]     = r_src[(NUM_CHAN - 1 - k) * 8 +: 8];
            w_b[k]     = r_tgt[(NUM_CHAN - 1 - k) * 8 +: 8];
            w_mag[k]   = (w_a[k] > w_b[k]) ? w_a[k] - w_b[k] : w_b[k] - w_a[k];
            w_trial[k] = {r_rem[k], r_quo[k][23]};
            w_ge[k]    = (w_trial[k] >= {1'b0, r_span});
            w_chan[k]  = r_neg[k] ? w_a[k] - r_quo[k][7:0] : w_a[k] + r_quo[k][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_active   <= 1'b0;
            r_count    <= '0;
            r_elapsed  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                if (i_kind == KIND_START) begin
                    r_active  <= (i_duration_ms != 16'd0);
                    r_count   <= '0;
                    r_elapsed <= '0;
                end else if (r_active) begin
                    if (!w_fire) begin
                        r_count   <= w_cnt_inc[7:0];
                        r_elapsed <= w_el_inc;
                    end else begin
                        r_count <= '0;
                        if (w_done) begin
                            r_elapsed <= r_span;
                            r_active  <= 1'b0;
                        end else begin
                            r_elapsed <= w_el_inc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_kind == KIND_START) begin
                r_src <= i_from_rgb;
                r_tgt <= i_to_rgb;
                r_span <= i_duration_ms;
                r_sel <= (i_duration_ms == 16'd0) ? SEL_TGT : SEL_SRC;
            end else begin
                r_sel <= w_done ? SEL_TGT : SEL_MIX;
            end
        end
        if (i_cmd.mul) begin
            r_step <= '0;
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_quo[k] <= 24'(r_elapsed) * 24'(w_mag[k]);
                r_rem[k] <= '0;
                r_neg[k] <= (w_a[k] > w_b[k]);
            end
        end else if (i_cmd.div_step) begin
            r_step <= r_step + STEP_W'(1);
            for (int k = 0; k < NUM_CHAN; k++) begin
                if (w_ge[k]) begin
                    r_rem[k] <= 16'(w_trial[k] - {1'b0, r_span});
                end else begin
                    r_rem[k] <= w_trial[k][15:0];
                end
                r_quo[k] <= {r_quo[k][22:0], w_ge[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (r_sel)
                SEL_SRC: r_out_data <= {r_src[7:0], r_src[15:8], r_src[23:16]};
                SEL_TGT: r_out_data <= {r_tgt[7:0], r_tgt[15:8], r_tgt[23:16]};
                SEL_MIX: r_out_data <= {w_chan[2], w_chan[1], w_chan[0]};
                default: r_out_data <= {r_tgt[7:0], r_tgt[15:8], r_tgt[23:16]};
            endcase
            r_out_last <= (r_sel == SEL_TGT);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule
